// ===== design/phasor_sine_oscillator_smoothed_amp_core_assert.svh =====
// Assertion macros for the phasor sine oscillator core.
// Depends on nothing; included by the top level only.
`ifndef PHASOR_SINE_OSCILLATOR_SMOOTHED_AMP_CORE_ASSERT_SVH
`define PHASOR_SINE_OSCILLATOR_SMOOTHED_AMP_CORE_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define PSA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psa assertion failed");

// Next-cycle implication under a synchronous reset.
`define PSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psa assertion failed");

`endif

// ===== design/psa_pkg.sv =====
// Package for the phasor sine oscillator: widths, constants and sequencer types.
// Depends on nothing; used by the interfaces and the top level.
package psa_pkg;

   localparam int FRAC_BITS = 22;
   localparam int TGT_W     = 15;
   localparam int SMP_W     = 24;
   localparam int AMP_W     = 23;
   localparam int COEFF_W   = 16;
   localparam int ACC_W     = 50;

   localparam logic signed [SMP_W-1:0] ONE_Q    = SMP_W'(1) <<< FRAC_BITS;
   localparam logic [AMP_W-1:0]        ONE_AMP  = AMP_W'(1) << FRAC_BITS;
   localparam logic [TGT_W-1:0]        FULL_Q14 = TGT_W'(16384);

   // Step counts of the serial units.
   localparam logic [5:0] MUL_LAST  = 6'd23;
   localparam logic [5:0] SQRT_LAST = 6'd22;
   localparam logic [5:0] DIV_LAST  = 6'd44;

   // Register indexes of the control port.
   localparam logic [1:0] REG_ROT_COS = 2'd0;
   localparam logic [1:0] REG_ROT_SIN = 2'd1;
   localparam logic [1:0] REG_COEFF   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_POST, ST_SQRT, ST_DIV, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      PH_AMP1, PH_AMP2, PH_OUT, PH_RE1, PH_RE2, PH_IM1, PH_IM2,
      PH_SQ1, PH_SQ2, PH_DIV_RE, PH_DIV_IM
   } phase_type;

endpackage

// ===== design/psa_req_if.sv =====
// Request channel: one sample tick word with target amplitude and chunk mark.
// Depends on psa_pkg.
interface psa_req_if import psa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TGT_W-1:0]  amp_goal;
   logic              end_of_chunk;

   modport source (output valid, amp_goal, end_of_chunk, input ready);
   modport sink   (input valid, amp_goal, end_of_chunk, output ready);
endinterface

// ===== design/psa_rsp_if.sv =====
// Response channel: one output sample word.
// Depends on psa_pkg.
interface psa_rsp_if import psa_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [SMP_W-1:0]  sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

// ===== design/phasor_sine_oscillator_smoothed_amp_core.sv =====
// Phasor sine oscillator with a two-stage amplitude smoother, bit-serial datapath.
// Depends on psa_pkg, psa_req_if, psa_rsp_if and the assertion macro header.
//
//   channel   direction  payload
//   req_chan  in         amp_goal[14:0], end_of_chunk
//   rsp_chan  out        sample_out[23:0] signed
//   csr_*     in         csr_index[1:0], csr_wdata[23:0]
//
// One shift-add multiplier (one multiplier bit per cycle) does all products;
// each product takes 24 steps and then a post step.
// A plain tick takes seven products plus accept and emit.
// An end-of-chunk tick adds two squares, a square root and two divisions;
// the divisions are skipped when the phasor is zero.
// Reset is synchronous; a new word is taken while the last sample waits in rsp.

`include "phasor_sine_oscillator_smoothed_amp_core_assert.svh"

module phasor_sine_oscillator_smoothed_amp_core import psa_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   psa_req_if.sink            req_chan,
   psa_rsp_if.source          rsp_chan,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [SMP_W-1:0]   csr_wdata
);

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   logic signed [SMP_W-1:0] cos_ff, sin_ff;
   logic [COEFF_W-1:0]      coeff_ff;
   logic signed [SMP_W-1:0] re_ff, re_in, im_ff, im_in;
   logic [AMP_W-1:0]        s1_ff, s1_in, s2_ff, s2_in;
   logic                    eoc_ff, eoc_in;
   logic signed [SMP_W:0]   mcand_ff, mcand_in;
   logic [SMP_W-1:0]        mplier_ff, mplier_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, psum_ff, psum_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic signed [SMP_W-1:0] y_ff, y_in, nre_ff, nre_in;
   logic [45:0]             rad_ff, rad_in;
   logic [25:0]             rem_ff, rem_in;
   logic [AMP_W-1:0]        root_ff, root_in;
   logic [44:0]             num_ff, num_in, quo_ff, quo_in;
   logic [24:0]             drem_ff, drem_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0] rsp_data_ff, rsp_data_in;

   logic signed [SMP_W-1:0] cos_sat, sin_sat;
   logic [TGT_W-1:0]        tgt_sat;
   logic signed [ACC_W-1:0] addend, sum_acc;
   logic [25:0]             rem_sh, trial;
   logic [24:0]             div_sh;
   logic                    qbit;
   logic [44:0]             quo_fin;
   logic signed [SMP_W-1:0] div_val;

   // Round half up by 2^FRAC_BITS, then clamp to the phasor range.
   function automatic logic signed [SMP_W-1:0] rnd_sat(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] r;
      r = (v + (ACC_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > ACC_W'(ONE_Q))       return ONE_Q;
      else if (r < -ACC_W'(ONE_Q)) return -ONE_Q;
      else                         return SMP_W'(r);
   endfunction

   // One smoother update: stage plus rounded product over 2^16, clamped to [0, ONE].
   function automatic logic [AMP_W-1:0] amp_upd(input logic [AMP_W-1:0] s,
                                                input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] r;
      r = $signed(ACC_W'(s)) + ((p + (ACC_W'(1) <<< (COEFF_W - 1))) >>> COEFF_W);
      if (r > $signed(ACC_W'(ONE_AMP))) return ONE_AMP;
      else if (r < 0)                   return '0;
      else                              return AMP_W'(r);
   endfunction

   // Rotator clamped to the unit range.
   assign cos_sat = (cos_ff > ONE_Q) ? ONE_Q : ((cos_ff < -ONE_Q) ? -ONE_Q : cos_ff);
   assign sin_sat = (sin_ff > ONE_Q) ? ONE_Q : ((sin_ff < -ONE_Q) ? -ONE_Q : sin_ff);
   assign tgt_sat = (req_chan.amp_goal > FULL_Q14) ? FULL_Q14
                                                   : req_chan.amp_goal;

   // Multiplier step: MSB first, the top multiplier bit has negative weight.
   assign addend  = !mplier_ff[SMP_W-1] ? '0 :
                    ((cnt_ff == '0) ? -ACC_W'(mcand_ff) : ACC_W'(mcand_ff));
   assign sum_acc = psum_ff + acc_ff;

   // Square root step: two radicand bits per cycle.
   assign rem_sh = {rem_ff[23:0], rad_ff[45:44]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // Restoring division step: one quotient bit per cycle.
   assign div_sh  = {drem_ff[23:0], num_ff[44]};
   assign qbit    = (div_sh >= {2'b00, root_ff});
   assign quo_fin = {quo_ff[43:0], qbit};
   assign div_val = (quo_fin > 45'(ONE_Q)) ? (neg_ff ? -ONE_Q : ONE_Q)
                   : (neg_ff ? -SMP_W'(quo_fin) : SMP_W'(quo_fin));

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   // Sequencer: next state and datapath loads.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      eoc_in       = eoc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      psum_in      = psum_ff;
      cnt_in       = cnt_ff;
      y_in         = y_ff;
      nre_in       = nre_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      drem_in      = drem_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               eoc_in    = req_chan.end_of_chunk;
               mcand_in  = $signed({2'b00, tgt_sat, 8'b0}) - $signed({2'b00, s1_ff});
               mplier_in = {8'b0, coeff_ff};
               acc_in    = '0;
               cnt_in    = '0;
               phase_in  = PH_AMP1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            acc_in    = (acc_ff <<< 1) + addend;
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == MUL_LAST) state_in = ST_POST;
         end
         ST_POST: begin
            // Finish the product just done and load the next one.
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MUL;
            case (phase_ff)
               PH_AMP1: begin
                  s1_in     = amp_upd(s1_ff, acc_ff);
                  mcand_in  = $signed({2'b00, amp_upd(s1_ff, acc_ff)}) -
                              $signed({2'b00, s2_ff});
                  mplier_in = {8'b0, coeff_ff};
                  phase_in  = PH_AMP2;
               end
               PH_AMP2: begin
                  s2_in     = amp_upd(s2_ff, acc_ff);
                  mcand_in  = {re_ff[SMP_W-1], re_ff};
                  mplier_in = {1'b0, amp_upd(s2_ff, acc_ff)};
                  phase_in  = PH_OUT;
               end
               PH_OUT: begin
                  y_in      = rnd_sat(acc_ff);
                  mcand_in  = {re_ff[SMP_W-1], re_ff};
                  mplier_in = cos_sat;
                  phase_in  = PH_RE1;
               end
               PH_RE1: begin
                  psum_in   = acc_ff;
                  mcand_in  = {im_ff[SMP_W-1], im_ff};
                  mplier_in = sin_sat;
                  phase_in  = PH_RE2;
               end
               PH_RE2: begin
                  nre_in    = rnd_sat(psum_ff - acc_ff);
                  mcand_in  = {re_ff[SMP_W-1], re_ff};
                  mplier_in = sin_sat;
                  phase_in  = PH_IM1;
               end
               PH_IM1: begin
                  psum_in   = acc_ff;
                  mcand_in  = {im_ff[SMP_W-1], im_ff};
                  mplier_in = cos_sat;
                  phase_in  = PH_IM2;
               end
               PH_IM2: begin
                  re_in     = nre_ff;
                  im_in     = rnd_sat(sum_acc);
                  mcand_in  = {nre_ff[SMP_W-1], nre_ff};
                  mplier_in = nre_ff;
                  phase_in  = PH_SQ1;
                  if (!eoc_ff) state_in = ST_EMIT;
               end
               PH_SQ1: begin
                  psum_in   = acc_ff;
                  mcand_in  = {im_ff[SMP_W-1], im_ff};
                  mplier_in = im_ff;
                  phase_in  = PH_SQ2;
               end
               default: begin
                  // Squares done: start the square root of the squared magnitude.
                  rad_in   = sum_acc[45:0];
                  rem_in   = '0;
                  root_in  = '0;
                  state_in = ST_SQRT;
               end
            endcase
         end
         ST_SQRT: begin
            rad_in = rad_ff << 2;
            cnt_in = cnt_ff + 6'd1;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[AMP_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[AMP_W-2:0], 1'b0};
            end
            if (cnt_ff == SQRT_LAST) begin
               cnt_in = '0;
               if (root_in == '0) begin
                  re_in    = ONE_Q;
                  im_in    = '0;
                  state_in = ST_EMIT;
               end else begin
                  neg_in   = re_ff[SMP_W-1];
                  num_in   = (45'(re_ff[SMP_W-1] ? -re_ff : re_ff) << FRAC_BITS) +
                             45'(root_in >> 1);
                  drem_in  = '0;
                  quo_in   = '0;
                  phase_in = PH_DIV_RE;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            num_in  = num_ff << 1;
            quo_in  = quo_fin;
            drem_in = qbit ? (div_sh - {2'b00, root_ff}) : div_sh;
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               if (phase_ff == PH_DIV_RE) begin
                  re_in    = div_val;
                  neg_in   = im_ff[SMP_W-1];
                  num_in   = (45'(im_ff[SMP_W-1] ? -im_ff : im_ff) << FRAC_BITS) +
                             45'(root_ff >> 1);
                  drem_in  = '0;
                  quo_in   = '0;
                  phase_in = PH_DIV_IM;
               end else begin
                  im_in    = div_val;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_AMP1;
         cos_ff       <= ONE_Q;
         sin_ff       <= '0;
         coeff_ff     <= COEFF_W'(2034);
         re_ff        <= ONE_Q;
         im_ff        <= '0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         re_ff        <= re_in;
         im_ff        <= im_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_ROT_COS: cos_ff   <= csr_wdata;
               REG_ROT_SIN: sin_ff   <= csr_wdata;
               REG_COEFF:   coeff_ff <= csr_wdata[COEFF_W-1:0];
               default:     ;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      eoc_ff      <= eoc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      psum_ff     <= psum_in;
      y_ff        <= y_in;
      nre_ff      <= nre_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      num_ff      <= num_in;
      quo_ff      <= quo_in;
      drem_ff     <= drem_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Checks on the sequencer and the held state.
   `PSA_ASSERT_IMPLY(a_amp_range, clock, reset, 1'b1, (s1_ff <= ONE_AMP) && (s2_ff <= ONE_AMP))
   `PSA_ASSERT_NEXT(a_accept_starts, clock, reset, req_chan.valid && req_chan.ready, (state_ff == ST_MUL) && (phase_ff == PH_AMP1))
   `PSA_ASSERT_IMPLY(a_phasor_range, clock, reset, state_ff == ST_IDLE, (re_ff <= ONE_Q) && (re_ff >= -ONE_Q) && (im_ff <= ONE_Q) && (im_ff >= -ONE_Q))

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the phasor sine oscillator core: directed table, rotator extremes, then random ticks.
// Depends on psa_pkg, psa_req_if, psa_rsp_if and the core itself.
`timescale 1ns / 1ps

module tb import psa_pkg::*; ();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = REG_ROT_COS;
   logic [SMP_W-1:0] csr_wdata = '0;

   psa_req_if req_chan ();
   psa_rsp_if rsp_chan ();

   phasor_sine_oscillator_smoothed_amp_core dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source), .csr_wr_en(csr_wr_en),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state, held in wide signed integers.
   longint rot_c, rot_s, coeff, ph_re, ph_im, amp1, amp2;
   logic signed [SMP_W-1:0] sample_queue[$];
   int errors = 0;
   int idle_pct = 28;
   bit rsp_hold = 1'b0;
   int quiet = 0;

   localparam longint ONE = longint'(1) <<< FRAC_BITS;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Half-up rounding right shift (floor of v + half).
   function automatic longint rnd_shift(longint v, int s);
      longint t;
      t = v + (longint'(1) <<< (s - 1));
      return t >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Round to nearest, halves away from zero.
   function automatic longint div_near(longint n, longint unsigned d);
      longint unsigned m, q;
      m = (n < 0) ? longint'(-n) : n;
      q = (m + d / 2) / d;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sext(logic [SMP_W-1:0] v);
      return longint'($signed(v));
   endfunction

   // Registers are written only once every sent word has come back.
   task automatic write_reg(logic [1:0] idx, logic [SMP_W-1:0] val);
      req_chan.valid <= 1'b0;
      while (sample_queue.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == REG_ROT_COS) rot_c = sext(val);
      else if (idx == REG_ROT_SIN) rot_s = sext(val);
      else if (idx == REG_COEFF) coeff = val[COEFF_W-1:0];
   endtask

   // Advance the oscillator model by one tick and return the sample.
   function automatic logic signed [SMP_W-1:0] next_sample(logic [TGT_W-1:0] tgt, bit eoc);
      longint tq, y, c, s, nre, nim, mag;
      longint unsigned sum;
      tq = longint'((tgt > FULL_Q14) ? FULL_Q14 : tgt) <<< (FRAC_BITS - 14);
      amp1 = clamp(amp1 + rnd_shift(coeff * (tq - amp1), 16), 0, ONE);
      amp2 = clamp(amp2 + rnd_shift(coeff * (amp1 - amp2), 16), 0, ONE);
      y = clamp(rnd_shift(amp2 * ph_re, FRAC_BITS), -ONE, ONE);
      c = clamp(rot_c, -ONE, ONE);
      s = clamp(rot_s, -ONE, ONE);
      nre = clamp(rnd_shift(c * ph_re - s * ph_im, FRAC_BITS), -ONE, ONE);
      nim = clamp(rnd_shift(s * ph_re + c * ph_im, FRAC_BITS), -ONE, ONE);
      ph_re = nre;
      ph_im = nim;
      if (eoc) begin
         sum = longint'(ph_re * ph_re) + longint'(ph_im * ph_im);
         mag = int_sqrt(sum);
         if (mag == 0) begin
            ph_re = ONE;
            ph_im = 0;
         end else begin
            ph_re = clamp(div_near(ph_re * ONE, mag), -ONE, ONE);
            ph_im = clamp(div_near(ph_im * ONE, mag), -ONE, ONE);
         end
      end
      return y[SMP_W-1:0];
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
   endtask

   // Send one tick word; the expected sample is either typed in or predicted.
   // The word stays offered after acceptance until the next call, a register write or a drain replaces or drops it.
   task automatic send_word(logic [TGT_W-1:0] tgt, bit eoc, bit fixed,
                            logic signed [SMP_W-1:0] want);
      logic signed [SMP_W-1:0] p;
      if ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.amp_goal <= tgt;
      req_chan.end_of_chunk <= eoc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      p = next_sample(tgt, eoc);
      sample_queue.push_back(fixed ? want : p);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (sample_queue.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   // Receiver: random stalls plus an explicit long hold-off.
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= !rsp_hold && ($urandom_range(99) >= idle_pct);
   end

   // Output checker and watchdog on cycles with no word accepted on either side.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (sample_queue.size() == 0) begin
               report("unexpected sample", rsp_chan.sample_out, 0);
            end else begin
               if (rsp_chan.sample_out !== sample_queue[0])
                  report("sample_out", rsp_chan.sample_out, sample_queue[0]);
               void'(sample_queue.pop_front());
            end
         end
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet > 20000) begin
               $display("CHECK FAILED");
               $finish;
            end
         end
      end
   end

   typedef struct {
      logic [TGT_W-1:0] tgt;
      bit eoc;
      bit fixed;
      logic signed [SMP_W-1:0] want;
   } tick_row_type;

   // Directed ticks; a zero target right after reset keeps both stages at zero.
   tick_row_type dir_rows[] = '{
      '{15'd0, 1'b0, 1'b1, 24'sd0},
      '{15'd0, 1'b0, 1'b0, 0},
      '{15'h7FFF, 1'b0, 1'b0, 0},
      '{15'd16385, 1'b1, 1'b0, 0},
      '{15'd16384, 1'b1, 1'b0, 0},
      '{15'd8192, 1'b0, 1'b0, 0},
      '{15'd1, 1'b1, 1'b0, 0},
      '{15'h5555, 1'b0, 1'b0, 0},
      '{15'h2AAA, 1'b1, 1'b0, 0}
   };

   task automatic random_phase(int n, int eoc_pct);
      for (int i = 0; i < n; i++)
         send_word(($urandom_range(99) < 10) ? 15'($urandom) :
                   15'($urandom_range(16384)), $urandom_range(99) < eoc_pct, 0, 0);
   endtask

   initial begin
      rot_c = ONE; rot_s = 0; coeff = 2034;
      ph_re = ONE; ph_im = 0; amp1 = 0; amp2 = 0;
      req_chan.valid = 1'b0;
      req_chan.amp_goal = '0;
      req_chan.end_of_chunk = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Full-speed coefficient so the smoother reaches its extremes quickly.
      write_reg(REG_COEFF, 24'd65535);
      foreach (dir_rows[i])
         send_word(dir_rows[i].tgt, dir_rows[i].eoc, dir_rows[i].fixed, dir_rows[i].want);
      // Rotator extremes: beyond +-ONE, gain above one, and a zero phasor.
      write_reg(REG_ROT_COS, 24'h7FFFFF);
      write_reg(REG_ROT_SIN, 24'h7FFFFF);
      send_word(16384, 0, 0, 0);
      send_word(16384, 1, 0, 0);
      write_reg(REG_ROT_COS, 24'h800000);
      write_reg(REG_ROT_SIN, 24'h800000);
      send_word(16384, 0, 0, 0);
      send_word(16384, 1, 0, 0);
      write_reg(REG_ROT_COS, 24'd0);
      write_reg(REG_ROT_SIN, 24'd0);
      send_word(16384, 0, 0, 0);
      send_word(16384, 1, 0, 0);
      send_word(16384, 0, 0, 0);
      write_reg(2'd3, 24'hFFFFFF);
      drain();

      // Random settings, a few phases.
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(REG_ROT_COS, 24'($urandom_range(8388607) - 4194304 + 0));
         write_reg(REG_ROT_SIN, (ph == 0) ? 24'h7FFFFF : 24'($urandom));
         write_reg(REG_COEFF, (ph == 1) ? 24'd0 : 24'($urandom_range(65535)));
         if (ph == 2) begin
            // Stretch with no idling, then a long receiver hold-off.
            idle_pct = 0;
            random_phase(100, 20);
            idle_pct = 28;
            fork
               begin
                  rsp_hold = 1'b1;
                  repeat (3000) @(negedge clock);
                  rsp_hold = 1'b0;
               end
               random_phase(10, 30);
            join
         end
         random_phase(190, 15);
         drain();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

// ===== phasor_sine_oscillator_smoothed_amp_core.f =====
+incdir+design
design/psa_pkg.sv
design/psa_req_if.sv
design/psa_rsp_if.sv
design/phasor_sine_oscillator_smoothed_amp_core.sv
tb/sv/tb.sv
